// ===== design/fole_pkg.sv =====
// fole_pkg: shared types and constants for the flagged ordered list engine
// no dependencies

package fole_pkg;

   localparam logic [7:0] ID_MASK = 8'h7f;

   typedef enum logic [2:0] {
      OP_ADD_PENDING = 3'd0,
      OP_ADD_STORED  = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_SETTLE      = 3'd3,
      OP_DROP        = 3'd4,
      OP_QUERY       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       pending;
      logic [7:0] id;
   } entry_type;

endpackage

// ===== design/flagged_ordered_list_engine_unit.sv =====
// flagged_ordered_list_engine_unit: top level of the flagged ordered list engine
// depends on fole_pkg and fole_mem
// entries live in one memory; search, removal and compaction walk it one entry a cycle
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | req_op, req_entry_id
//   rsp     | out | rsp_valid/rsp_stall  | rsp_accepted, rsp_found, rsp_entry_count,
//           |     |                      | rsp_settled_count
//
// adds and unused codes: no walk; the result is registered from the finish state
// remove, settle, drop, query: walk the list through the single memory read port,
//   one entry per cycle; settle and query stop at the hit
// one item at a time; a new beat is taken while the last result waits on rsp_stall
// reset clears the list; no clearing pass, entries past the count are never read

module flagged_ordered_list_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_entry_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic       rsp_found,
   output logic [6:0] rsp_entry_count,
   output logic [6:0] rsp_settled_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   fole_pkg::state_type state_ff, state_in;
   fole_pkg::op_type    op_ff, op_in;
   logic [7:0]          id_ff, id_in;
   logic [CW-1:0]       length_ff, length_in;
   logic [CW-1:0]       settled_ff, settled_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [IW-1:0]       proc_idx_ff, proc_idx_in;
   logic                proc_vld_ff, proc_vld_in;
   logic                hit_ff, hit_in;
   logic                accepted_ff, accepted_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accepted_ff, rsp_accepted_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [6:0]          rsp_entry_count_ff, rsp_entry_count_in;
   logic [6:0]          rsp_settled_count_ff, rsp_settled_count_in;

   logic                req_acc;
   logic                walk_start;
   logic                walk_done;
   logic                rsp_load;
   logic                is_match;
   logic                is_last;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   fole_pkg::entry_type wr_data;
   logic                rd_en;
   fole_pkg::entry_type rd_data;
   fole_pkg::op_type    req_code;

   assign req_code  = fole_pkg::op_type'(req_op);
   assign req_stall = (state_ff != fole_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_load  = (state_ff == fole_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign is_match  = (rd_data.id == id_ff);
   assign is_last   = ((CW'(proc_idx_ff) + CW'(1)) == length_ff);

   always_comb begin
      walk_start = 1'b0;
      case (req_code) inside
         fole_pkg::OP_REMOVE, fole_pkg::OP_SETTLE, fole_pkg::OP_DROP,
         fole_pkg::OP_QUERY: walk_start = (length_ff != '0);
         default:            walk_start = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fole_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = walk_start ? fole_pkg::ST_WALK : fole_pkg::ST_FINISH;
            end
         end
         fole_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = fole_pkg::ST_FINISH;
            end
         end
         fole_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = fole_pkg::ST_IDLE;
            end
         end
         default: state_in = fole_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      settled_in  = settled_ff;
      rd_idx_in   = rd_idx_ff;
      keep_in     = keep_ff;
      proc_idx_in = rd_idx_ff[IW-1:0];
      proc_vld_in = 1'b0;
      hit_in      = hit_ff;
      accepted_in = accepted_ff;
      walk_done   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = length_ff[IW-1:0];
      wr_data     = rd_data;
      rd_en       = 1'b0;

      unique case (state_ff)
         fole_pkg::ST_IDLE: begin
            if (req_acc) begin
               op_in       = req_code;
               id_in       = req_entry_id;
               rd_idx_in   = '0;
               keep_in     = '0;
               hit_in      = 1'b0;
               accepted_in = 1'b1;
               case (req_code) inside
                  fole_pkg::OP_ADD_PENDING, fole_pkg::OP_ADD_STORED: begin
                     if (req_code == fole_pkg::OP_ADD_PENDING) begin
                        wr_data.pending = 1'b1;
                        wr_data.id      = req_entry_id;
                     end else begin
                        wr_data.pending = req_entry_id[7];
                        wr_data.id      = req_entry_id & fole_pkg::ID_MASK;
                     end
                     if (length_ff < CW'(CAPACITY)) begin
                        wr_en     = 1'b1;
                        length_in = length_ff + CW'(1);
                        if (!wr_data.pending) begin
                           settled_in = settled_ff + CW'(1);
                        end
                     end else begin
                        accepted_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         fole_pkg::ST_WALK: begin
            if (proc_vld_ff) begin
               case (op_ff)
                  fole_pkg::OP_REMOVE: begin
                     if (hit_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = proc_idx_ff - IW'(1);
                     end else if (is_match) begin
                        hit_in = 1'b1;
                        if (!rd_data.pending) begin
                           settled_in = settled_ff - CW'(1);
                        end
                     end
                  end
                  fole_pkg::OP_SETTLE: begin
                     if (is_match && rd_data.pending) begin
                        hit_in          = 1'b1;
                        wr_en           = 1'b1;
                        wr_addr         = proc_idx_ff;
                        wr_data.pending = 1'b0;
                        settled_in      = settled_ff + CW'(1);
                     end
                  end
                  fole_pkg::OP_DROP: begin
                     if (!rd_data.pending) begin
                        wr_en   = 1'b1;
                        wr_addr = keep_ff[IW-1:0];
                        keep_in = keep_ff + CW'(1);
                     end
                  end
                  fole_pkg::OP_QUERY: begin
                     if (is_match) begin
                        hit_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               walk_done = is_last || (hit_in && (op_ff == fole_pkg::OP_SETTLE ||
                                                  op_ff == fole_pkg::OP_QUERY));
               if (walk_done) begin
                  if (op_ff == fole_pkg::OP_REMOVE && hit_in) begin
                     length_in = length_ff - CW'(1);
                  end
                  if (op_ff == fole_pkg::OP_DROP) begin
                     length_in = keep_in;
                  end
               end
            end
            if (!walk_done && rd_idx_ff < length_ff) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CW'(1);
               proc_vld_in = 1'b1;
            end
         end
         fole_pkg::ST_FINISH: ;
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_accepted_in      = rsp_accepted_ff;
      rsp_found_in         = rsp_found_ff;
      rsp_entry_count_in   = rsp_entry_count_ff;
      rsp_settled_count_in = rsp_settled_count_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_accepted_in      = accepted_ff;
         rsp_found_in         = hit_ff;
         rsp_entry_count_in   = 7'(length_ff);
         rsp_settled_count_in = 7'(settled_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fole_pkg::ST_IDLE;
         length_ff    <= '0;
         settled_ff   <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         settled_ff   <= settled_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff                <= op_in;
      id_ff                <= id_in;
      rd_idx_ff            <= rd_idx_in;
      keep_ff              <= keep_in;
      proc_idx_ff          <= proc_idx_in;
      hit_ff               <= hit_in;
      accepted_ff          <= accepted_in;
      rsp_accepted_ff      <= rsp_accepted_in;
      rsp_found_ff         <= rsp_found_in;
      rsp_entry_count_ff   <= rsp_entry_count_in;
      rsp_settled_count_ff <= rsp_settled_count_in;
   end

   fole_mem #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_settled_count = rsp_settled_count_ff;

   a_settled_le_length: assert property (@(posedge clock) disable iff (reset)
      settled_ff <= length_ff)
      else $error("settled count exceeds entry count");

   a_length_le_capacity: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fole_pkg::ST_FINISH)
      else $error("result loaded outside finish");

   a_no_write_in_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != fole_pkg::ST_FINISH)
      else $error("memory write while finishing");

   a_compact_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fole_pkg::ST_WALK && op_ff == fole_pkg::OP_DROP && wr_en)
         |-> keep_ff <= CW'(proc_idx_ff))
      else $error("compaction write ahead of walk");

endmodule

// ===== design/fole_mem.sv =====
// fole_mem: single write port, single registered read port entry memory
// depends on fole_pkg for the entry type

module fole_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  fole_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output fole_pkg::entry_type rd_data
);

   fole_pkg::entry_type mem_ff [DEPTH];
   fole_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/flagged_ordered_list_engine_unit_test.sv =====
// flagged_ordered_list_engine_unit_test: self-checking bench for the flagged ordered list engine
// depends on fole_pkg and flagged_ordered_list_engine_unit; a directed table, then list-aware
// random beats, scored against an in-bench copy of the list; fixed rows carry their own result

module flagged_ordered_list_engine_unit_test;

   localparam int CAPACITY       = 64;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_ITEMS   = 830;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_type;

   typedef struct packed {
      logic       accepted;
      logic       found;
      logic [6:0] entry_count;
      logic [6:0] settled_count;
   } list_result_type;

   typedef struct {
      logic [2:0]      op;
      logic [7:0]      id;
      bit              fixed;
      list_result_type want;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_op;
   logic [7:0] req_entry_id;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_accepted;
   logic       rsp_found;
   logic [6:0] rsp_entry_count;
   logic [6:0] rsp_settled_count;

   // bench copy of the list
   logic [7:0] list_ids [CAPACITY];
   logic       list_pending [CAPACITY];
   int         list_len;

   list_result_type awaited_results[$];
   plan_row_type    directed_plan[$];

   int error_count = 0;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   bit holdoff_request;

   flagged_ordered_list_engine_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_entry_id(req_entry_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_found(rsp_found),
      .rsp_entry_count(rsp_entry_count),
      .rsp_settled_count(rsp_settled_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0d] mismatch: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic [7:0] id);
      list_result_type r;
      int i;
      int hit;
      int keep;
      int settled;
      r = '0;
      r.accepted = 1'b1;
      hit = -1;
      case (op) inside
         fole_pkg::OP_ADD_PENDING, fole_pkg::OP_ADD_STORED: begin
            if (list_len >= CAPACITY) begin
               r.accepted = 1'b0;
            end else begin
               list_ids[list_len]     = (op == fole_pkg::OP_ADD_STORED) ?
                                        (id & fole_pkg::ID_MASK) : id;
               list_pending[list_len] = (op == fole_pkg::OP_ADD_STORED) ? id[7] : 1'b1;
               list_len++;
            end
         end
         fole_pkg::OP_REMOVE, fole_pkg::OP_QUERY: begin
            for (i = 0; i < list_len && hit < 0; i++)
               if (list_ids[i] == id) hit = i;
            if (hit >= 0) begin
               r.found = 1'b1;
               if (op == fole_pkg::OP_REMOVE) begin
                  for (i = hit; i < list_len - 1; i++) begin
                     list_ids[i]     = list_ids[i + 1];
                     list_pending[i] = list_pending[i + 1];
                  end
                  list_len--;
               end
            end
         end
         fole_pkg::OP_SETTLE: begin
            for (i = 0; i < list_len && hit < 0; i++)
               if (list_ids[i] == id && list_pending[i]) hit = i;
            if (hit >= 0) begin
               list_pending[hit] = 1'b0;
               r.found = 1'b1;
            end
         end
         fole_pkg::OP_DROP: begin
            keep = 0;
            for (i = 0; i < list_len; i++) begin
               if (!list_pending[i]) begin
                  list_ids[keep]     = list_ids[i];
                  list_pending[keep] = 1'b0;
                  keep++;
               end
            end
            list_len = keep;
         end
         default: ;
      endcase
      settled = 0;
      for (i = 0; i < list_len; i++)
         if (!list_pending[i]) settled++;
      r.entry_count   = list_len[6:0];
      r.settled_count = settled[6:0];
      return r;
   endfunction

   function automatic void add_plan_row(input logic [2:0] op, input logic [7:0] id,
                                        input bit fixed, input int acc, input int fnd,
                                        input int cnt, input int stl);
      plan_row_type row;
      row.op    = op;
      row.id    = id;
      row.fixed = fixed;
      row.want  = {acc[0], fnd[0], cnt[6:0], stl[6:0]};
      directed_plan.push_back(row);
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [7:0] id, input bit fixed,
                            input list_result_type want);
      list_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid    <= 1'b0;
         req_op       <= 3'($urandom);
         req_entry_id <= 8'($urandom);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_entry_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_list_op(op, id);
      awaited_results.push_back(fixed ? want : predicted);
   endtask

   // result side: stall pattern plus the long hold-off
   initial begin
      int hold_left;
      bit holdoff_taken;
      hold_left     = 0;
      holdoff_taken = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request && !holdoff_taken) begin
            holdoff_taken = 1'b1;
            hold_left     = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = awaited_results.pop_front();
            if (rsp_accepted !== want.accepted)
               report_mismatch($sformatf("accepted got %0b want %0b", rsp_accepted,
                                         want.accepted));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found got %0b want %0b", rsp_found, want.found));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d", rsp_entry_count,
                                         want.entry_count));
            if (rsp_settled_count !== want.settled_count)
               report_mismatch($sformatf("settled_count got %0d want %0d", rsp_settled_count,
                                         want.settled_count));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("flagged_ordered_list_engine_unit_test: errors");
      $finish;
   end

   initial begin
      mix_type    mix;
      int         seg_left;
      int         roll;
      logic [2:0] op;
      logic [7:0] id;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = '0;
      req_entry_id    = '0;
      holdoff_request = 1'b0;
      list_len        = 0;
      seg_left        = 0;
      mix             = MIX_FILL;
      send_idle_pct   = 20;
      recv_stall_pct  = 64;
      for (int i = 0; i < CAPACITY; i++) begin
         list_ids[i]     = '0;
         list_pending[i] = 1'b0;
      end

      //           op                        id     fixed acc fnd cnt stl
      add_plan_row(fole_pkg::OP_QUERY,       8'h00, 1,    1,  0,  0,  0);
      add_plan_row(fole_pkg::OP_REMOVE,      8'hff, 1,    1,  0,  0,  0);
      add_plan_row(fole_pkg::OP_SETTLE,      8'h00, 1,    1,  0,  0,  0);
      add_plan_row(fole_pkg::OP_DROP,        8'h00, 1,    1,  0,  0,  0);
      add_plan_row(OP_SPARE_6,               8'h55, 1,    1,  0,  0,  0);
      add_plan_row(OP_SPARE_7,               8'haa, 1,    1,  0,  0,  0);
      add_plan_row(fole_pkg::OP_ADD_PENDING, 8'hff, 1,    1,  0,  1,  0);
      add_plan_row(fole_pkg::OP_ADD_STORED,  8'h00, 1,    1,  0,  2,  1);
      add_plan_row(fole_pkg::OP_ADD_STORED,  8'hff, 1,    1,  0,  3,  1);
      add_plan_row(fole_pkg::OP_ADD_STORED,  8'h7f, 1,    1,  0,  4,  2);
      add_plan_row(fole_pkg::OP_ADD_PENDING, 8'h00, 1,    1,  0,  5,  2);
      add_plan_row(fole_pkg::OP_QUERY,       8'hff, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_QUERY,       8'h80, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_SETTLE,      8'h7f, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_SETTLE,      8'h7f, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_SETTLE,      8'h00, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_REMOVE,      8'h7f, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_REMOVE,      8'h55, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_DROP,        8'h00, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_ADD_PENDING, 8'h80, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_ADD_STORED,  8'h80, 0,    0,  0,  0,  0);
      add_plan_row(fole_pkg::OP_DROP,        8'hff, 0,    0,  0,  0,  0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k])
         send_item(directed_plan[k].op, directed_plan[k].id, directed_plan[k].fixed,
                   directed_plan[k].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 64;
            recv_stall_pct = 20;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct   = 0;
            recv_stall_pct  = 0;
            holdoff_request = 1'b1;
         end
         if (seg_left == 0) begin
            mix      = (n == 0) ? MIX_FILL : mix_type'($urandom_range(2));
            seg_left = (n == 0) ? 100 : $urandom_range(40, 100);
         end
         seg_left--;
         roll = $urandom_range(99);
         case (mix)
            MIX_FILL:
               op = roll < 45 ? fole_pkg::OP_ADD_PENDING :
                    roll < 85 ? fole_pkg::OP_ADD_STORED :
                    roll < 90 ? fole_pkg::OP_SETTLE :
                    roll < 95 ? fole_pkg::OP_QUERY : fole_pkg::OP_REMOVE;
            MIX_DRAIN:
               op = roll < 40 ? fole_pkg::OP_REMOVE :
                    roll < 60 ? fole_pkg::OP_SETTLE :
                    roll < 68 ? fole_pkg::OP_DROP :
                    roll < 80 ? fole_pkg::OP_QUERY :
                    roll < 90 ? fole_pkg::OP_ADD_PENDING : fole_pkg::OP_ADD_STORED;
            default:
               op = roll < 4 ? (roll[0] ? OP_SPARE_7 : OP_SPARE_6) : 3'($urandom_range(5));
         endcase
         // mostly ids already in the list so that searches hit
         if (list_len > 0 && $urandom_range(99) < 65) begin
            id = list_ids[$urandom_range(list_len - 1)];
            if (op == fole_pkg::OP_ADD_STORED) id[7] = 1'($urandom_range(1));
         end else begin
            id = 8'($urandom_range(255));
         end
         send_item(op, id, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("flagged_ordered_list_engine_unit_test: clean");
      else
         $display("flagged_ordered_list_engine_unit_test: errors");
      $finish;
   end

endmodule

// ===== flagged_ordered_list_engine_unit.f =====
design/fole_pkg.sv
design/fole_mem.sv
design/flagged_ordered_list_engine_unit.sv
verif/flagged_ordered_list_engine_unit_test.sv
